### rtl/core/atp_pkg.sv
// atp_pkg: shared types and constants of the atan2 polynomial approximation.
// Holds the fixed-point formats, the minimax coefficients and the pipeline tag.
// No dependencies.
`default_nettype none

package atp_pkg;

  // Default configuration
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  // Ratio r: unsigned, one integer bit plus 16 fraction bits (holds 1.0 exactly)
  localparam int RATIO_FRAC = 16;
  localparam int RATIO_W    = RATIO_FRAC + 1;

  // Horner accumulator: signed, 16 fraction bits
  localparam int ACC_W      = 20;
  localparam int POLY_TERMS = 7;

  // Product poly*r and folded angle: unsigned, 32 fraction bits
  localparam int T_FRAC = 32;
  localparam int T_W    = ACC_W - 1 + RATIO_W;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [T_W-1:0]          tval_t;

  // Minimax coefficients in Q1.16, highest power first
  localparam acc_t POLY_COEF [0:POLY_TERMS-1] = '{
    20'sd473, -20'sd2298, 20'sd5353, -20'sd8765, 20'sd13013, -20'sd21840, 20'sd65536
  };

  // pi and pi/2 with 32 fraction bits, rounded to nearest
  localparam tval_t PI_Q32      = T_W'(64'd13493037705);
  localparam tval_t HALF_PI_Q32 = T_W'(64'd6746518852);

  // Side information that travels with every transaction down the pipeline
  typedef struct packed {
    logic valid;
    logic ybig;   // |y| > |x|
    logic xneg;   // x < 0
    logic yneg;   // y < 0
    logic zero;   // both coordinates zero
  } tag_t;

endpackage

`default_nettype wire

### rtl/core/atp_in_if.sv
// atp_in_if: input channel carrying one coordinate pair per transaction.
// Depends on atp_pkg for the default coordinate width.
`default_nettype none

interface atp_in_if #(
  parameter int COORD_WIDTH = atp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] x_coord;

  modport source (output valid, output y_coord, output x_coord, input ready);
  modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

`default_nettype wire

### rtl/core/atp_out_if.sv
// atp_out_if: result channel carrying one angle per transaction.
// Depends on atp_pkg for the default angle precision.
`default_nettype none

interface atp_out_if #(
  parameter int ANGLE_FRAC_BITS = atp_pkg::ANGLE_FRAC_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+2:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

### rtl/core/atp_divider.sv
// atp_divider: magnitude/octant stage followed by a pipelined restoring divider
// that forms r = round(min/max) in Q1.16, one quotient bit per stage.
// Depends on atp_pkg.
`default_nettype none

module atp_divider #(
  parameter int COORD_WIDTH = atp_pkg::COORD_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire         [COORD_WIDTH-1:0]     y_coord,
  input  wire         [COORD_WIDTH-1:0]     x_coord,
  output logic        [atp_pkg::RATIO_W-1:0] ratio,
  output atp_pkg::tag_t                     tag_o
);
  import atp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = CW + RATIO_FRAC;   // numerator width
  localparam int NSTG  = RATIO_W;           // one stage per quotient bit

  // Magnitudes and octant
  logic [CW-1:0] ay, ax, hi_val, lo_val;
  logic          yneg, xneg, ybig;
  logic [NW-1:0] num;
  tag_t          tag_nxt;

  always_comb begin
    yneg   = y_coord[CW-1];
    xneg   = x_coord[CW-1];
    ay     = yneg ? (CW'(0) - y_coord) : y_coord;
    ax     = xneg ? (CW'(0) - x_coord) : x_coord;
    ybig   = ay > ax;
    hi_val = ybig ? ay : ax;
    lo_val = ybig ? ax : ay;
    // (lo << 16) + hi/2 gives round-half-up of the quotient
    num    = {lo_val, RATIO_FRAC'(0)} + NW'(hi_val >> 1);
    tag_nxt.valid = in_valid;
    tag_nxt.ybig  = ybig;
    tag_nxt.xneg  = xneg;
    tag_nxt.yneg  = yneg;
    tag_nxt.zero  = (hi_val == '0);
  end

  // Per-stage divider state
  logic [CW-1:0]      rem_r  [0:NSTG];
  logic [CW-1:0]      hi_r   [0:NSTG];
  logic [NSTG-1:0]    nlo_r  [0:NSTG];
  logic [NSTG-1:0]    q_r    [0:NSTG];
  tag_t               tag_r  [0:NSTG];

  // Entry register: partial remainder starts with the numerator bits above the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_nxt;
    end
    if (en) begin
      rem_r[0] <= {1'b0, num[NW-1:NSTG]};
      hi_r[0]  <= hi_val;
      nlo_r[0] <= num[NSTG-1:0];
      q_r[0]   <= '0;
    end
  end

  // Restoring divide: stage s resolves quotient bit NSTG-1-s
  for (genvar s = 0; s < NSTG; s++) begin : g_div
    localparam int K = NSTG - 1 - s;
    logic [CW:0] trial, diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[s], nlo_r[s][K]};
      diff  = trial - {1'b0, hi_r[s]};
      ge    = trial >= {1'b0, hi_r[s]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s+1] <= '0;
      end else if (en) begin
        tag_r[s+1] <= tag_r[s];
      end
      if (en) begin
        rem_r[s+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        hi_r[s+1]  <= hi_r[s];
        nlo_r[s+1] <= nlo_r[s];
        q_r[s+1]   <= {q_r[s][NSTG-2:0], ge};
      end
    end
  end

  assign ratio = q_r[NSTG];
  assign tag_o = tag_r[NSTG];

endmodule

`default_nettype wire

### rtl/core/atp_poly.sv
// atp_poly: squares the ratio, runs the six Horner steps (one per stage) and
// multiplies the polynomial by r, giving atan(r) with 32 fraction bits.
// Depends on atp_pkg.
`default_nettype none

module atp_poly (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                en,
  input  wire         [atp_pkg::RATIO_W-1:0] ratio,
  input  atp_pkg::tag_t                      tag_i,
  output atp_pkg::tval_t                     t_val,
  output atp_pkg::tag_t                      tag_o
);
  import atp_pkg::*;

  localparam int NH  = POLY_TERMS - 1;           // Horner stages
  localparam int PW  = ACC_W + RATIO_W + 1;      // signed product width
  localparam int SQW = 2 * RATIO_W;

  logic [RATIO_W-1:0] r_r   [0:NH];
  logic [RATIO_W-1:0] r2_r  [0:NH];
  acc_t               acc_r [0:NH];
  tag_t               tag_r [0:NH];

  // Square stage: r2 = (r*r + 0.5) >> 16
  logic [SQW-1:0] sq;
  always_comb begin
    sq = SQW'(ratio) * SQW'(ratio) + SQW'(1 << (RATIO_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
    if (en) begin
      r_r[0]   <= ratio;
      r2_r[0]  <= sq[RATIO_FRAC +: RATIO_W];
      acc_r[0] <= POLY_COEF[0];
    end
  end

  // Horner steps: acc = round_half_up(acc * r2) + coef[j]
  for (genvar j = 1; j <= NH; j++) begin : g_horner
    logic signed [PW-1:0] prod, prod_sh;
    acc_t                 acc_nxt;

    always_comb begin
      prod    = acc_r[j-1] * $signed({1'b0, r2_r[j-1]});
      prod_sh = (prod + $signed(PW'(1 << (RATIO_FRAC - 1)))) >>> RATIO_FRAC;
      acc_nxt = prod_sh[ACC_W-1:0] + POLY_COEF[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j] <= '0;
      end else if (en) begin
        tag_r[j] <= tag_r[j-1];
      end
      if (en) begin
        r_r[j]   <= r_r[j-1];
        r2_r[j]  <= r2_r[j-1];
        acc_r[j] <= acc_nxt;
      end
    end
  end

  // Final product poly * r; a negative polynomial is clamped to zero
  logic [ACC_W-2:0] acc_pos;
  tval_t            t_r;
  tag_t             tag_p_r;

  always_comb begin
    acc_pos = acc_r[NH][ACC_W-1] ? '0 : acc_r[NH][ACC_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p_r <= '0;
    end else if (en) begin
      tag_p_r <= tag_r[NH];
    end
    if (en) begin
      t_r <= T_W'(acc_pos) * T_W'(r_r[NH]);
    end
  end

  assign t_val = t_r;
  assign tag_o = tag_p_r;

endmodule

`default_nettype wire

### rtl/core/atp_fold.sv
// atp_fold: folds the first-octant angle into the full circle, then rounds to
// the output precision and applies the sign; ends in the output register.
// Depends on atp_pkg.
`default_nettype none

module atp_fold #(
  parameter int ANGLE_FRAC_BITS = atp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  atp_pkg::tval_t                    t_val,
  input  atp_pkg::tag_t                     tag_i,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle
);
  import atp_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = T_FRAC - ANGLE_FRAC_BITS;

  // Octant fold
  tval_t t_y, t_x, tf_r;
  tag_t  tag_f_r;

  always_comb begin
    t_y = tag_i.ybig ? (HALF_PI_Q32 - t_val) : t_val;
    t_x = tag_i.xneg ? (PI_Q32 - t_y) : t_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_f_r <= '0;
    end else if (en) begin
      tag_f_r <= tag_i;
    end
    if (en) begin
      tf_r <= t_x;
    end
  end

  // Round magnitude half away from zero, then sign
  logic [T_W:0]    sum;
  logic [AW-1:0]   mag, angle_nxt;
  logic            valid_r;
  logic [AW-1:0]   angle_r;

  always_comb begin
    sum       = {1'b0, tf_r} + ((T_W + 1)'(1) << (SH - 1));
    mag       = sum[SH +: AW];
    angle_nxt = tag_f_r.yneg ? (AW'(0) - mag) : mag;
    if (tag_f_r.zero) begin
      angle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= tag_f_r.valid;
    end
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = valid_r;
  assign angle     = $signed(angle_r);

endmodule

`default_nettype wire

### rtl/core/atan2_poly_approx.sv
// atan2_poly_approx: four-quadrant arctangent, top level.
// Depends on atp_pkg, atp_in_if, atp_out_if, atp_divider, atp_poly, atp_fold.
//
// Usage:
//   in_ch  : valid/ready channel, one (y_coord, x_coord) pair per transaction,
//            two's complement integers of COORD_WIDTH bits.
//   out_ch : valid/ready channel, one angle per transaction, signed radians in
//            Q3.ANGLE_FRAC_BITS, range -pi..pi. Both coordinates zero give 0.
//   Stages from input transaction to result valid: 1 octant stage,
//   17 divider stages, 1 square, 6 Horner, 1 product, 1 fold, 1 round/output.
//   Throughput: one transaction per cycle unless stalled; results leave in input order.
//   The 17-stage restoring divider (one quotient bit per stage) sets the depth.
//   Stall: the whole pipeline advances as one; while the output register holds
//   an untaken result, in_ch.ready is low and every stage keeps its contents.
//   Bubbles occupy stages like items, so nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
`default_nettype none

module atan2_poly_approx #(
  parameter int COORD_WIDTH     = atp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = atp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  atp_in_if.sink    in_ch,
  atp_out_if.source out_ch
);
  import atp_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = T_FRAC - ANGLE_FRAC_BITS;
  // Largest legal magnitude: pi rounded to the output precision
  localparam logic [T_W:0] PI_RND_FULL = ({1'b0, PI_Q32} + ((T_W + 1)'(1) << (SH - 1))) >> SH;
  localparam logic signed [AW-1:0] PI_OUT = $signed(PI_RND_FULL[AW-1:0]);

  logic               en;
  logic               out_valid;
  logic [RATIO_W-1:0] ratio;
  tag_t               tag_div, tag_poly;
  tval_t              t_val;

  // Global advance: output register empty or being taken
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  atp_divider #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .y_coord  (COORD_WIDTH'(in_ch.y_coord)),
    .x_coord  (COORD_WIDTH'(in_ch.x_coord)),
    .ratio    (ratio),
    .tag_o    (tag_div)
  );

  atp_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ratio (ratio),
    .tag_i (tag_div),
    .t_val (t_val),
    .tag_o (tag_poly)
  );

  atp_fold #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .t_val     (t_val),
    .tag_i     (tag_poly),
    .out_valid (out_valid),
    .angle     (out_ch.angle)
  );

  assign out_ch.valid = out_valid;

  // Checks

  // No result may appear right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A held result freezes the whole pipeline, input side included
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // Every angle lies within -pi..pi at the output precision
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.angle <= PI_OUT && out_ch.angle >= -PI_OUT))
    else $error("angle outside -pi..pi");

endmodule

`default_nettype wire

### tb/atp_angle_checker.sv
// atp_angle_checker: watches both channels of the atan2 block, predicts each angle
// and compares it with the result that leaves the block. Depends on atp_pkg,
// atp_in_if and atp_out_if.
module atp_angle_checker (
  input  logic clk,
  input  logic rst_n,
  atp_in_if    in_mon,
  atp_out_if   out_mon,
  output int   fail_count,
  output int   outstanding,
  output int   checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW    = atp_pkg::COORD_WIDTH_DEF;
  localparam int FRAC  = atp_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int AW    = FRAC + 3;
  localparam int SHIFT = 32 - FRAC;

  // pi and pi/2 with 32 fraction bits
  localparam logic [63:0] PI_FIX32      = 64'd13493037705;
  localparam logic [63:0] HALF_PI_FIX32 = 64'd6746518852;

  // Minimax coefficients in Q1.16, highest power of r^2 first
  localparam longint HORNER_COEF [0:6] = '{473, -2298, 5353, -8765, 13013, -21840, 65536};

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] angle_t;

  typedef struct {
    coord_t y;
    coord_t x;
    angle_t angle;
  } angle_entry_t;

  angle_entry_t expected_angles [$];
  int mismatches = 0;
  int checked    = 0;

  // Four-quadrant arctangent in fixed point: octant ratio, Horner, fold, round
  function automatic angle_t atan2_fixed(input coord_t y, input coord_t x);
    logic [CW:0]  mag_y, mag_x, big, tiny;
    logic [CW:0]  ratio;
    logic [CW:0]  ratio_sq;
    logic         y_big;
    longint       horner;
    logic [63:0]  arc;
    logic [AW-1:0] mag;
    mag_y = y[CW-1] ? (CW+1)'(1 << CW) - {1'b0, y} : {1'b0, y};
    mag_x = x[CW-1] ? (CW+1)'(1 << CW) - {1'b0, x} : {1'b0, x};
    y_big = mag_y > mag_x;
    big   = y_big ? mag_y : mag_x;
    tiny  = y_big ? mag_x : mag_y;
    if (big == 0) begin
      return '0;
    end
    // ratio in [0,1] with 16 fraction bits, rounded half up
    ratio    = (CW+1)'(((64'(tiny) << 16) + 64'(big >> 1)) / 64'(big));
    ratio_sq = (CW+1)'((64'(ratio) * 64'(ratio) + 64'd32768) >> 16);
    // Horner steps round half toward +inf (arithmetic shift floors)
    horner = HORNER_COEF[0];
    for (int k = 1; k < 7; k++) begin
      horner = ((horner * longint'(ratio_sq) + 64'sd32768) >>> 16) + HORNER_COEF[k];
    end
    if (horner < 0) begin
      horner = 0;
    end
    arc = 64'(horner) * 64'(ratio);
    if (y_big) begin
      arc = HALF_PI_FIX32 - arc;
    end
    if (x[CW-1]) begin
      arc = PI_FIX32 - arc;
    end
    // magnitude rounded half away from zero, sign last
    arc = (arc + (64'd1 << (SHIFT - 1))) >> SHIFT;
    mag = arc[AW-1:0];
    return y[CW-1] ? angle_t'(-mag) : angle_t'(mag);
  endfunction

  // Results are checked before the same edge's input is queued
  always @(posedge clk) begin
    angle_entry_t head;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_angles.size() == 0) begin
          $error("angle: expected none outstanding, actual %0d", out_mon.angle);
          mismatches++;
        end else begin
          head = expected_angles.pop_front();
          checked++;
          if (out_mon.angle !== head.angle) begin
            $error("angle for y=%0d x=%0d: expected %0d, actual %0d",
                   head.y, head.x, head.angle, out_mon.angle);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_angles.push_back('{in_mon.y_coord, in_mon.x_coord,
                                    atan2_fixed(in_mon.y_coord, in_mon.x_coord)});
      end
    end
    fail_count    <= mismatches;
    outstanding   <= expected_angles.size();
    checked_count <= checked;
  end

endmodule

### tb/atan2_poly_approx_tb.sv
// atan2_poly_approx_tb: drives coordinate pairs into the atan2 block with random
// idling and a long output stall; the verdict comes from atp_angle_checker.
// Depends on atp_pkg, atp_in_if, atp_out_if, atan2_poly_approx, atp_angle_checker.
module atan2_poly_approx_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = atp_pkg::COORD_WIDTH_DEF;
  localparam int RAND_PAIRS = 1500;
  localparam int STALL_LEN  = 200;
  localparam int DRAIN_WAIT = 40;

  typedef logic signed [CW-1:0] coord_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int  pairs_sent = 0;
  bit  steady     = 1'b0;  // no idling on either side while set
  int  fail_count;
  int  outstanding;
  int  checked_count;

  atp_in_if  in_ch ();
  atp_out_if out_ch ();

  atan2_poly_approx i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  atp_angle_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard limit on run time
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offer one pair, idling at random first; returns after the transaction
  task automatic send_pair(input coord_t y, input coord_t x);
    while (!steady && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.y_coord <= y;
    in_ch.x_coord <= x;
    do @(posedge clk); while (!in_ch.ready);
    pairs_sent++;
  endtask

  // Result side: random stalls, one long hold-off to back up the pipeline
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && pairs_sent >= 1000) begin
        hold_done = 1'b1;
        hold_left = STALL_LEN - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    coord_t directed_y [] = '{0, 0, 0, 1, -1, 32767, -32768, -32768, 0, -32768,
                              32767, 1, -1, 32767, 1, -32768, 1, 100, -5, 3,
                              -32768, 32767, -32767, 7, -7};
    coord_t directed_x [] = '{0, 1, -1, 0, 0, 32767, -32768, 0, -32768, 32767,
                              -32768, -1, 1, 1, 32767, 1, -32768, -100, 3, -5,
                              -32767, -32767, -32768, -7, -7};
    coord_t extremes [5] = '{0, -32768, 32767, -1, 1};
    int     m, d;
    coord_t y, x;

    in_ch.valid   <= 1'b0;
    in_ch.y_coord <= '0;
    in_ch.x_coord <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Axes, diagonals, most negative values, zero pair
    foreach (directed_y[i]) begin
      send_pair(directed_y[i], directed_x[i]);
    end

    for (int n = 0; n < RAND_PAIRS; n++) begin
      steady = (n >= 500 && n < 800);
      case ($urandom_range(7))
        0, 1, 2, 3: begin
          y = coord_t'($urandom);
          x = coord_t'($urandom);
        end
        4: begin
          y = coord_t'(int'($urandom_range(16)) - 8);
          x = coord_t'(int'($urandom_range(16)) - 8);
        end
        5: begin
          // near the diagonal: ratio close to one from either side
          m = $urandom_range(32767);
          d = m + int'($urandom_range(4)) - 2;
          if (d > 32767) d = 32767;
          if (d < 0) d = 0;
          y = coord_t'($urandom_range(1) ? -m : m);
          x = coord_t'($urandom_range(1) ? -d : d);
          if ($urandom_range(1)) begin
            {y, x} = {x, y};
          end
        end
        default: begin
          y = coord_t'($urandom);
          x = extremes[$urandom_range(4)];
          if ($urandom_range(1)) begin
            {y, x} = {x, y};
          end
        end
      endcase
      send_pair(y, x);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d coordinate pairs sent, %0d angles checked, one %0d-cycle output hold",
             pairs_sent, checked_count, STALL_LEN);
    $display("summary: directed edge cases, random full-range, small and near-diagonal pairs");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
